>>> design/spt_pkg.sv
// shared constants, command codes and controller command type for the sorted priority table
package spt_pkg;

   localparam int CAPACITY      = 16;
   localparam int ID_BITS       = 8;

   localparam int CMD_BITS      = 2;
   localparam int REQ_ID_BITS   = 8;
   localparam int PRIO_BITS     = 7;
   localparam int COUNT_OUT_BITS = 5;

   // stored identifier width: the request carries at most eight bits
   localparam int SID_BITS      = (ID_BITS < REQ_ID_BITS) ? ID_BITS : REQ_ID_BITS;
   localparam int COUNT_BITS    = $clog2(CAPACITY + 1);
   localparam int COUNT_EXT_BITS = (COUNT_BITS > COUNT_OUT_BITS) ? COUNT_BITS : COUNT_OUT_BITS;

   localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_REMOVE = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_FIND   = 2'd2;

   typedef struct packed {
      logic capture;
      logic scan;
      logic write;
      logic publish;
   } ctrl_cmd_type;

endpackage

>>> design/spt_controller.sv
// sequencing state machine: capture, scan, write and publish one transaction at a time
module spt_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output spt_pkg::ctrl_cmd_type cmd
);
   import spt_pkg::*;

   localparam logic [1:0] S_IDLE    = 2'd0;
   localparam logic [1:0] S_SCAN    = 2'd1;
   localparam logic [1:0] S_WRITE   = 2'd2;
   localparam logic [1:0] S_PUBLISH = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;
   logic       slot_free;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   // output register may be reloaded once the old result has gone or is leaving now
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.scan    = 1'b0;
      cmd.write   = 1'b0;
      cmd.publish = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            state_in = S_WRITE;
         end
         S_WRITE: begin
            cmd.write = 1'b1;
            state_in  = S_PUBLISH;
         end
         S_PUBLISH: begin
            if (slot_free) begin
               cmd.publish = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> design/spt_datapath.sv
// sorted slot table with per-slot compare, shift update and result register
module spt_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  spt_pkg::ctrl_cmd_type               cmd,
   input  logic [spt_pkg::CMD_BITS-1:0]        req_command,
   input  logic [spt_pkg::REQ_ID_BITS-1:0]     req_entry_id,
   input  logic [spt_pkg::PRIO_BITS-1:0]       req_priority_req,
   output logic                                rsp_found,
   output logic [spt_pkg::PRIO_BITS-1:0]       rsp_found_priority,
   output logic                                rsp_rejected,
   output logic [spt_pkg::COUNT_OUT_BITS-1:0]  rsp_entry_count,
   output logic                                rsp_head_valid,
   output logic [spt_pkg::REQ_ID_BITS-1:0]     rsp_head_id,
   output logic [spt_pkg::PRIO_BITS-1:0]       rsp_head_priority
);
   import spt_pkg::*;

   logic [SID_BITS-1:0]   ids_ff   [CAPACITY];
   logic [SID_BITS-1:0]   ids_in   [CAPACITY];
   logic [PRIO_BITS-1:0]  prios_ff [CAPACITY];
   logic [PRIO_BITS-1:0]  prios_in [CAPACITY];
   logic [COUNT_BITS-1:0] occ_ff, occ_in;

   // captured transaction
   logic [CMD_BITS-1:0]   op_ff;
   logic [SID_BITS-1:0]   id_ff;
   logic [PRIO_BITS-1:0]  prio_ff;

   // scan results
   logic [CAPACITY-1:0]   gt, gt_ff;
   logic [CAPACITY-1:0]   match;
   logic [CAPACITY-1:0]   after, after_ff;
   logic                  full, full_ff;

   // per-transaction flags
   logic                  found_ff, found_in;
   logic [PRIO_BITS-1:0]  found_prio_ff, found_prio_in;
   logic                  rejected_ff, rejected_in;
   logic [CAPACITY-1:0]   first;

   // response register
   logic                  rsp_found_ff;
   logic [PRIO_BITS-1:0]  rsp_found_prio_ff;
   logic                  rsp_rejected_ff;
   logic [COUNT_OUT_BITS-1:0] rsp_count_ff;
   logic                  rsp_head_valid_ff;
   logic [REQ_ID_BITS-1:0] rsp_head_id_ff;
   logic [PRIO_BITS-1:0]  rsp_head_prio_ff;
   logic [COUNT_EXT_BITS-1:0] count_ext;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_command;
         id_ff   <= req_entry_id[SID_BITS-1:0];
         prio_ff <= req_priority_req;
      end
   end

   // every slot compares against the request on its own
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         gt[i]    = (COUNT_BITS'(i) < occ_ff) && (prios_ff[i] > prio_ff);
         match[i] = (COUNT_BITS'(i) < occ_ff) && (ids_ff[i] == id_ff);
      end
      for (int i = 0; i < CAPACITY; i++) begin
         after[i] = |(match & ((CAPACITY'(2) << i) - CAPACITY'(1)));
      end
      full = (occ_ff >= COUNT_BITS'(CAPACITY));
   end

   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         gt_ff    <= gt;
         after_ff <= after;
         full_ff  <= full;
      end
   end

   assign first = after_ff & ~(after_ff << 1);

   always_comb begin
      found_in      = 1'b0;
      found_prio_in = '0;
      rejected_in   = 1'b0;
      occ_in        = occ_ff;
      for (int i = 0; i < CAPACITY; i++) begin
         ids_in[i]   = ids_ff[i];
         prios_in[i] = prios_ff[i];
      end
      case (op_ff)
         CMD_INSERT: begin
            if (full_ff) begin
               rejected_in = 1'b1;
            end else begin
               occ_in = occ_ff + COUNT_BITS'(1);
               for (int i = 0; i < CAPACITY; i++) begin
                  if (!gt_ff[i]) begin
                     if (i == 0) begin
                        ids_in[i]   = id_ff;
                        prios_in[i] = prio_ff;
                     end else if (gt_ff[i-1]) begin
                        ids_in[i]   = id_ff;
                        prios_in[i] = prio_ff;
                     end else begin
                        ids_in[i]   = ids_ff[i-1];
                        prios_in[i] = prios_ff[i-1];
                     end
                  end
               end
            end
         end
         CMD_REMOVE, CMD_FIND: begin
            found_in = after_ff[CAPACITY-1];
            for (int i = 0; i < CAPACITY; i++) begin
               if (first[i]) begin
                  found_prio_in = found_prio_in | prios_ff[i];
               end
            end
            if (op_ff == CMD_REMOVE && after_ff[CAPACITY-1]) begin
               occ_in = occ_ff - COUNT_BITS'(1);
               // close the gap from the matched slot down
               for (int i = 0; i < CAPACITY - 1; i++) begin
                  if (after_ff[i]) begin
                     ids_in[i]   = ids_ff[i+1];
                     prios_in[i] = prios_ff[i+1];
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.write) begin
         for (int i = 0; i < CAPACITY; i++) begin
            ids_ff[i]   <= ids_in[i];
            prios_ff[i] <= prios_in[i];
         end
         found_ff      <= found_in;
         found_prio_ff <= found_prio_in;
         rejected_ff   <= rejected_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else if (cmd.write) begin
         occ_ff <= occ_in;
      end
   end

   assign count_ext = COUNT_EXT_BITS'(occ_ff);

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_found_ff      <= found_ff;
         rsp_found_prio_ff <= found_prio_ff;
         rsp_rejected_ff   <= rejected_ff;
         rsp_count_ff      <= count_ext[COUNT_OUT_BITS-1:0];
         rsp_head_valid_ff <= (occ_ff != '0);
         rsp_head_id_ff    <= (occ_ff != '0) ? REQ_ID_BITS'(ids_ff[0]) : '0;
         rsp_head_prio_ff  <= (occ_ff != '0) ? prios_ff[0] : '0;
      end
   end

   assign rsp_found          = rsp_found_ff;
   assign rsp_found_priority = rsp_found_prio_ff;
   assign rsp_rejected       = rsp_rejected_ff;
   assign rsp_entry_count    = rsp_count_ff;
   assign rsp_head_valid     = rsp_head_valid_ff;
   assign rsp_head_id        = rsp_head_id_ff;
   assign rsp_head_priority  = rsp_head_prio_ff;

endmodule

>>> design/sorted_priority_table.sv
// top level of the sorted priority table: controller plus slot datapath
//
//   channel | direction | handshake          | payload
//   req_    | in        | req_valid/req_stall | command, entry_id, priority_req
//   rsp_    | out       | rsp_valid/rsp_stall | found, found_priority, rejected,
//           |           |                     | entry_count, head_valid, head_id,
//           |           |                     | head_priority
//
// one transaction at a time: accept, scan, write and publish, so a result is
// registered in the publish step and a new request is taken only once the
// previous one is published; the scan compares all slots in parallel against the request.
// reset clears the entry count and the controller; slot contents are left as is.
// the next request is taken while a result waits; a stalled result holds the
// publish step until it has left.
module sorted_priority_table (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [spt_pkg::CMD_BITS-1:0]        req_command,
   input  logic [spt_pkg::REQ_ID_BITS-1:0]     req_entry_id,
   input  logic [spt_pkg::PRIO_BITS-1:0]       req_priority_req,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_found,
   output logic [spt_pkg::PRIO_BITS-1:0]       rsp_found_priority,
   output logic                                rsp_rejected,
   output logic [spt_pkg::COUNT_OUT_BITS-1:0]  rsp_entry_count,
   output logic                                rsp_head_valid,
   output logic [spt_pkg::REQ_ID_BITS-1:0]     rsp_head_id,
   output logic [spt_pkg::PRIO_BITS-1:0]       rsp_head_priority
);
   import spt_pkg::*;

   ctrl_cmd_type cmd;

   spt_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   spt_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_command        (req_command),
      .req_entry_id       (req_entry_id),
      .req_priority_req   (req_priority_req),
      .rsp_found          (rsp_found),
      .rsp_found_priority (rsp_found_priority),
      .rsp_rejected       (rsp_rejected),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_head_valid     (rsp_head_valid),
      .rsp_head_id        (rsp_head_id),
      .rsp_head_priority  (rsp_head_priority)
   );

endmodule

>>> verif/sorted_priority_table_tb.sv
// testbench for the sorted priority table: directed and random commands checked against a predictor
module sorted_priority_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import spt_pkg::*;

   // command 3 is not decoded by the block and must leave the table alone
   localparam logic [CMD_BITS-1:0]    CMD_UNUSED = 2'd3;
   localparam logic [REQ_ID_BITS-1:0] ID_MASK    = REQ_ID_BITS'((1 << SID_BITS) - 1);
   localparam int                     MAX_SHOWN  = 10;

   typedef struct packed {
      logic                      found;
      logic [PRIO_BITS-1:0]      found_priority;
      logic                      rejected;
      logic [COUNT_OUT_BITS-1:0] entry_count;
      logic                      head_valid;
      logic [REQ_ID_BITS-1:0]    head_id;
      logic [PRIO_BITS-1:0]      head_priority;
   } table_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [CMD_BITS-1:0]       req_command = CMD_INSERT;
   logic [REQ_ID_BITS-1:0]    req_entry_id = '0;
   logic [PRIO_BITS-1:0]      req_priority_req = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_found;
   logic [PRIO_BITS-1:0]      rsp_found_priority;
   logic                      rsp_rejected;
   logic [COUNT_OUT_BITS-1:0] rsp_entry_count;
   logic                      rsp_head_valid;
   logic [REQ_ID_BITS-1:0]    rsp_head_id;
   logic [PRIO_BITS-1:0]      rsp_head_priority;

   // predicted table contents, slot 0 at the head
   logic [REQ_ID_BITS-1:0] table_ids [CAPACITY];
   logic [PRIO_BITS-1:0]   table_prios [CAPACITY];
   int                     table_count = 0;

   table_result_type pending_results [$];
   int               mismatch_count = 0;
   int               sender_idle_pct = 0;
   int               receiver_stall_pct = 0;
   int               hold_left = 0;

   sorted_priority_table uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_entry_id       (req_entry_id),
      .req_priority_req   (req_priority_req),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_found          (rsp_found),
      .rsp_found_priority (rsp_found_priority),
      .rsp_rejected       (rsp_rejected),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_head_valid     (rsp_head_valid),
      .rsp_head_id        (rsp_head_id),
      .rsp_head_priority  (rsp_head_priority)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // applies one command to the predicted table and returns the result it should give
   function automatic table_result_type table_apply(input logic [CMD_BITS-1:0] cmd,
                                                    input logic [REQ_ID_BITS-1:0] id_in,
                                                    input logic [PRIO_BITS-1:0] prio);
      table_result_type       res;
      logic [REQ_ID_BITS-1:0] id;
      int                     pos;
      res = '0;
      id  = id_in & ID_MASK;
      if (cmd == CMD_INSERT) begin
         if (table_count >= CAPACITY) begin
            res.rejected = 1'b1;
         end else begin
            pos = 0;
            while (pos < table_count && table_prios[pos] > prio) pos++;
            for (int i = table_count; i > pos; i--) begin
               table_ids[i]   = table_ids[i-1];
               table_prios[i] = table_prios[i-1];
            end
            table_ids[pos]   = id;
            table_prios[pos] = prio;
            table_count++;
         end
      end else if (cmd == CMD_REMOVE || cmd == CMD_FIND) begin
         pos = 0;
         while (pos < table_count && table_ids[pos] != id) pos++;
         if (pos < table_count) begin
            res.found          = 1'b1;
            res.found_priority = table_prios[pos];
            if (cmd == CMD_REMOVE) begin
               for (int i = pos; i + 1 < table_count; i++) begin
                  table_ids[i]   = table_ids[i+1];
                  table_prios[i] = table_prios[i+1];
               end
               table_count--;
            end
         end
      end
      res.entry_count = COUNT_OUT_BITS'(table_count);
      res.head_valid  = (table_count > 0);
      if (table_count > 0) begin
         res.head_id       = table_ids[0];
         res.head_priority = table_prios[0];
      end
      return res;
   endfunction

   // offers one command, holding it until the block takes the transaction
   task automatic send_command(input logic [CMD_BITS-1:0] cmd,
                               input logic [REQ_ID_BITS-1:0] id,
                               input logic [PRIO_BITS-1:0] prio);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_entry_id     <= id;
      req_priority_req <= prio;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_results.push_back(table_apply(cmd, id, prio));
   endtask

   function automatic logic [PRIO_BITS-1:0] random_priority();
      case ($urandom_range(3))
         0: return PRIO_BITS'($urandom_range(127));
         1: return PRIO_BITS'($urandom_range(100, 95));
         2: return PRIO_BITS'($urandom_range(3));
         default: return PRIO_BITS'($urandom_range(100));
      endcase
   endfunction

   // lookups mostly aim at stored identifiers so that hits are common
   function automatic logic [REQ_ID_BITS-1:0] random_lookup_id();
      if (table_count > 0 && $urandom_range(99) < 70)
         return table_ids[$urandom_range(table_count - 1)] | (~ID_MASK & REQ_ID_BITS'($urandom));
      else if ($urandom_range(1))
         return REQ_ID_BITS'($urandom_range(15));
      else
         return REQ_ID_BITS'($urandom_range(255));
   endfunction

   task automatic run_random_items(input int count, input int insert_pct);
      int                     pick;
      logic [REQ_ID_BITS-1:0] id;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < insert_pct) begin
            id = $urandom_range(1) ? REQ_ID_BITS'($urandom_range(15))
                                   : REQ_ID_BITS'($urandom_range(255));
            send_command(CMD_INSERT, id, random_priority());
         end else if (pick < insert_pct + (96 - insert_pct) / 2) begin
            send_command(CMD_REMOVE, random_lookup_id(), random_priority());
         end else if (pick < 96) begin
            send_command(CMD_FIND, random_lookup_id(), random_priority());
         end else begin
            send_command(CMD_UNUSED, REQ_ID_BITS'($urandom), PRIO_BITS'($urandom));
         end
      end
   endtask

   task automatic set_idling(input int send_pct, input int stall_pct);
      sender_idle_pct    = send_pct;
      receiver_stall_pct = stall_pct;
   endtask

   task automatic test_directed_cases();
      set_idling(0, 0);
      send_command(CMD_FIND,   8'h00, 7'd0);
      send_command(CMD_REMOVE, 8'hff, 7'd0);
      send_command(CMD_UNUSED, 8'hff, 7'h7f);
      send_command(CMD_INSERT, 8'h00, 7'd0);
      send_command(CMD_INSERT, 8'hff, 7'd127);
      send_command(CMD_INSERT, 8'haa, 7'd100);
      // equal priority: the newer entry goes first
      send_command(CMD_INSERT, 8'h55, 7'd100);
      send_command(CMD_FIND,   8'haa, 7'd3);
      send_command(CMD_FIND,   8'h00, 7'd0);
      send_command(CMD_INSERT, 8'h00, 7'd50);
      send_command(CMD_FIND,   8'h00, 7'd0);
      send_command(CMD_REMOVE, 8'h55, 7'd0);
      send_command(CMD_REMOVE, 8'h07, 7'd0);
      send_command(CMD_REMOVE, 8'hff, 7'h7f);
      send_command(CMD_UNUSED, 8'h00, 7'd0);
      send_command(CMD_REMOVE, 8'h00, 7'd0);
      send_command(CMD_REMOVE, 8'h00, 7'd0);
      send_command(CMD_REMOVE, 8'haa, 7'd0);
      send_command(CMD_FIND,   8'haa, 7'd0);
   endtask

   task automatic test_full_table();
      set_idling(0, 0);
      while (table_count < CAPACITY)
         send_command(CMD_INSERT, REQ_ID_BITS'($urandom), random_priority());
      repeat (3) send_command(CMD_INSERT, REQ_ID_BITS'($urandom), random_priority());
      send_command(CMD_FIND, random_lookup_id(), 7'd0);
      // drain from the tail so every slot position is removed once
      while (table_count > 0)
         send_command(CMD_REMOVE, table_ids[table_count - 1], 7'd0);
   endtask

   task automatic test_no_idling();
      set_idling(0, 0);
      run_random_items(200, 60);
      run_random_items(200, 40);
   endtask

   task automatic test_sender_gaps();
      set_idling(52, 0);
      run_random_items(350, 50);
   endtask

   task automatic test_result_stalls();
      set_idling(0, 52);
      run_random_items(350, 55);
   endtask

   task automatic test_both_idle();
      set_idling(17, 17);
      run_random_items(200, 70);
      run_random_items(200, 35);
   endtask

   task automatic test_input_backpressure();
      set_idling(0, 0);
      hold_left = 300;
      run_random_items(40, 50);
   endtask

   always @(posedge clock) begin
      if (hold_left > 0) hold_left <= hold_left - 1;
   end

   // result checker, also drives the receiver stall
   always @(posedge clock) begin
      table_result_type actual, predicted;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         actual = {rsp_found, rsp_found_priority, rsp_rejected, rsp_entry_count,
                   rsp_head_valid, rsp_head_id, rsp_head_priority};
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_SHOWN)
               $display("unexpected transaction on result channel: %p", actual);
         end else begin
            predicted = pending_results.pop_front();
            if (actual !== predicted) begin
               mismatch_count++;
               if (mismatch_count <= MAX_SHOWN)
                  $display("mismatch: expected %p, got %p", predicted, actual);
            end
         end
      end
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= (hold_left > 0) || ($urandom_range(99) < receiver_stall_pct);
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_full_table();
      test_no_idling();
      test_sender_gaps();
      test_result_stalls();
      test_both_idle();
      test_input_backpressure();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("PASS sorted_priority_table");
      else
         $display("FAIL sorted_priority_table");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL sorted_priority_table");
      $finish;
   end

endmodule
